### sv/mspr_pkg.sv
// ----------------------------------------------------------------------------
// mspr_pkg
// Codes, limits and the CRC-8 (poly 0xD5) update for the MSP v2 frame receiver.
// ----------------------------------------------------------------------------
package mspr_pkg;

  // largest payload size that is taken; larger frames are dropped
  localparam int unsigned MaxPayload = 256;

  localparam logic [7:0] CrcPoly    = 8'hD5;
  localparam logic [7:0] SyncDollar = 8'h24;
  localparam logic [7:0] SyncX      = 8'h58;
  localparam logic [7:0] TypeReq    = 8'h3C;
  localparam logic [7:0] TypeResp   = 8'h3E;
  localparam logic [7:0] TypeErr    = 8'h21;

  typedef enum logic [1:0] {
    KIND_REQUEST  = 2'd0,
    KIND_RESPONSE = 2'd1,
    KIND_ERROR    = 2'd2
  } frame_kind_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ACCEPTED  = 3'd1,
    EV_CRC_BAD   = 3'd2,
    EV_ERR_GOOD  = 3'd3,
    EV_OVERSIZE  = 3'd4
  } event_e;

  // one byte of CRC-8, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/mspr_if.sv
// ----------------------------------------------------------------------------
// mspr_if
// Valid/ready channels of the MSP v2 frame receiver: received bytes in,
// per-byte parse results out.
// ----------------------------------------------------------------------------
interface mspr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface mspr_result_if;
  logic        valid;
  logic        ready;
  logic        in_frame;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [1:0]  frame_kind;
  logic [15:0] function_id;
  logic [15:0] payload_length;
  logic        frame_end;
  logic [2:0]  event_res;

  modport source (
    output valid, input ready,
    output in_frame, output payload_valid, output payload_byte, output payload_index,
    output frame_kind, output function_id, output payload_length,
    output frame_end, output event_res
  );
  modport sink (
    input valid, output ready,
    input in_frame, input payload_valid, input payload_byte, input payload_index,
    input frame_kind, input function_id, input payload_length,
    input frame_end, input event_res
  );
endinterface

### sv/msp_v2_frame_receiver.sv
// ----------------------------------------------------------------------------
// msp_v2_frame_receiver
// Byte-wise MSP v2 frame parser with CRC-8 check and payload pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i  : one received serial byte per transaction (data_byte).
//   res_o : exactly one result per byte: frame status, payload byte and
//           index when the byte is payload, header fields of the current
//           frame, and a frame_end/event_res pair at the crc byte, on a bad
//           type byte or when an oversize frame is dropped.
//   The result of an accepted byte is registered and is valid from the cycle
//   after it is taken. Throughput is one byte per cycle while res_o takes
//   each result; the parse state update and the 8-step crc update fit
//   between the state registers and the result register.
//   The result register is the only buffer: while a result waits, a new
//   byte is still taken in the cycle the receiver takes that result, so
//   rx_i.ready follows res_o.ready when the register is full.
//   Reset (rst_ni low) returns the parser to hunting for '$', clears the
//   crc and header fields and empties the result register.
// ----------------------------------------------------------------------------
module msp_v2_frame_receiver (
  input  logic clk_i,
  input  logic rst_ni,
  mspr_byte_if.sink     rx_i,
  mspr_result_if.source res_o
);
  import mspr_pkg::*;

  localparam logic [2:0] PH_DOLLAR  = 3'd0;
  localparam logic [2:0] PH_X       = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_FLAG    = 3'd3;
  localparam logic [2:0] PH_FUNC    = 3'd4;
  localparam logic [2:0] PH_SIZE    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_CRC     = 3'd7;

  localparam logic [16:0] MaxLen = 17'(MaxPayload);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  crc_q, crc_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] func_q, func_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;

  logic        out_valid_q;
  logic        accept;
  logic [7:0]  b;
  logic [7:0]  crc_next;
  logic [15:0] cnt_inc;

  logic        pv, fend, inf;
  logic [2:0]  ev;
  logic [7:0]  pidx;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.data_byte;
  assign crc_next   = crc8_update(crc_q, b);
  assign cnt_inc    = cnt_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    kind_d  = kind_q;
    func_d  = func_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    pv      = 1'b0;
    pidx    = 8'd0;
    fend    = 1'b0;
    ev      = EV_NONE;
    unique case (phase_q)
      PH_DOLLAR: begin
        if (b == SyncDollar) phase_d = PH_X;
      end
      PH_X: begin
        phase_d = (b == SyncX) ? PH_TYPE : PH_DOLLAR;
      end
      PH_TYPE: begin
        if (b == TypeReq || b == TypeResp || b == TypeErr) begin
          kind_d  = (b == TypeReq) ? KIND_REQUEST :
                    ((b == TypeResp) ? KIND_RESPONSE : KIND_ERROR);
          crc_d   = 8'd0;
          func_d  = 16'd0;
          len_d   = 16'd0;
          cnt_d   = 16'd0;
          phase_d = PH_FLAG;
        end else begin
          phase_d = PH_DOLLAR;
          fend    = 1'b1;
        end
      end
      PH_FLAG: begin
        crc_d   = crc_next;
        cnt_d   = 16'd0;
        phase_d = PH_FUNC;
      end
      PH_FUNC: begin
        crc_d = crc_next;
        if (cnt_q == 16'd0) begin
          func_d = {8'd0, b};
          cnt_d  = 16'd1;
        end else begin
          func_d  = {b, func_q[7:0]};
          cnt_d   = 16'd0;
          phase_d = PH_SIZE;
        end
      end
      PH_SIZE: begin
        crc_d = crc_next;
        if (cnt_q == 16'd0) begin
          len_d = {8'd0, b};
          cnt_d = 16'd1;
        end else begin
          len_d = {b, len_q[7:0]};
          cnt_d = 16'd0;
          if ({1'b0, b, len_q[7:0]} > MaxLen) begin
            phase_d = PH_DOLLAR;
            fend    = 1'b1;
            ev      = EV_OVERSIZE;
          end else if ({b, len_q[7:0]} == 16'd0) begin
            phase_d = PH_CRC;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_d = crc_next;
        pv    = 1'b1;
        pidx  = cnt_q[7:0];
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) phase_d = PH_CRC;
      end
      PH_CRC: begin
        if (crc_q == b) begin
          ev = (kind_q == KIND_ERROR) ? EV_ERR_GOOD : EV_ACCEPTED;
        end else begin
          ev = EV_CRC_BAD;
        end
        fend    = 1'b1;
        phase_d = PH_DOLLAR;
      end
    endcase
    inf = (phase_d >= PH_TYPE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DOLLAR;
      crc_q   <= 8'd0;
      kind_q  <= 2'd0;
      func_q  <= 16'd0;
      len_q   <= 16'd0;
      cnt_q   <= 16'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      kind_q  <= kind_d;
      func_q  <= func_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_o.in_frame       <= inf;
      res_o.payload_valid  <= pv;
      res_o.payload_byte   <= pv ? b : 8'd0;
      res_o.payload_index  <= pidx;
      res_o.frame_kind     <= (inf || ev != EV_NONE) ? kind_d : 2'd0;
      res_o.function_id    <= (inf || ev != EV_NONE) ? func_d : 16'd0;
      res_o.payload_length <= (inf || ev != EV_NONE) ? len_d : 16'd0;
      res_o.frame_end      <= fend;
      res_o.event_res      <= ev;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule
